// ----- rtl/core/pic_pkg.sv -----
// Shared types and constants for the PI controller with conditional integration.
// Used by pic_gain_mul and by the top level pi_controller_conditional_integration.
`timescale 1ns / 1ps

package pic_pkg;

    localparam int DATA_WIDTH_DEF     = 32;
    localparam int GAIN_FRAC_BITS_DEF = 24;
    localparam int GAIN_W             = 32;
    localparam int CFG_IDX_W          = 4;
    localparam int KIND_W             = 2;

    localparam int LIMIT_LOW_RESET  = -65536;
    localparam int LIMIT_HIGH_RESET = 65536;

    typedef enum logic [KIND_W-1:0] {
        KIND_CALC   = 2'd0,
        KIND_PRESET = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 4'd0,
        CFG_STEP_IGAIN = 4'd1,
        CFG_LIMIT_LOW  = 4'd2,
        CFG_LIMIT_HIGH = 4'd3
    } t_cfg_idx;

endpackage

// ----- rtl/core/pic_gain_mul.sv -----
// Gain product: signed error times unsigned fixed point gain, floor shift, magnitude cap.
// Depends on pic_pkg for the gain width.
`timescale 1ns / 1ps

module pic_gain_mul
    import pic_pkg::*;
#(
    parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic signed [DATA_WIDTH:0]   i_err,
    input  logic        [GAIN_W-1:0]     i_gain,
    output logic signed [DATA_WIDTH+9:0] o_prod
);

    localparam int IW = DATA_WIDTH + 8;
    localparam int PW = IW + 2;
    localparam int FW = DATA_WIDTH + GAIN_W + 2;

    localparam logic signed [FW-1:0] CAP_POS = FW'(1) << IW;
    localparam logic signed [FW-1:0] CAP_NEG = -CAP_POS;

    logic signed [FW-1:0] w_full;
    logic signed [FW-1:0] w_shift;
    logic signed [FW-1:0] w_capped;

    assign w_full  = FW'(i_err) * FW'($signed({1'b0, i_gain}));
    // arithmetic shift rounds toward minus infinity
    assign w_shift = w_full >>> GAIN_FRAC_BITS;

    always_comb begin
        if (w_shift > CAP_POS) begin
            w_capped = CAP_POS;
        end else if (w_shift < CAP_NEG) begin
            w_capped = CAP_NEG;
        end else begin
            w_capped = w_shift;
        end
    end

    assign o_prod = w_capped[PW-1:0];

endmodule

// ----- rtl/core/pi_controller_conditional_integration.sv -----
// PI controller with conditional-integration anti-windup, four stage pipeline.
// Depends on pic_pkg and pic_gain_mul.
`timescale 1ns / 1ps
//
// Usage:
//   s_axis carries one command word: tuser holds the kind (compute, preset, clear),
//   tdata holds reference, feedback and desired output. m_axis returns one result
//   word per command: tdata holds the drive value, tuser the clamped and accepted
//   flags. The cfg channel writes gains and limits by index; it is always ready
//   and must only be used while no command is in flight.
//   Throughput: one command per cycle while the receiver does not stall. The
//   integral update (add, saturate, sum, compare with the limits) closes within
//   the last stage, so a command uses the integral left by the one just ahead
//   of it.
//   Stages: input register, error, two gain products, result plus integral.
//   Reset clears the integral, gains to zero, limits to -1.0 / +1.0 and empties
//   the pipeline. When the receiver stalls, the result word is held and the
//   stages ahead fill up one by one; s_axis_tready drops once the input stage
//   is occupied and cannot move on.

module pi_controller_conditional_integration
    import pic_pkg::*;
#(
    parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    localparam int IN_TDATA_W    = ((3 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W   = ((DATA_WIDTH + 7) / 8) * 8,
    localparam int CFG_DATA_W    = (DATA_WIDTH > GAIN_W) ? DATA_WIDTH : GAIN_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // reference, feedback, preset value, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic [KIND_W-1:0]      s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // drive, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // clamped, accepted
    output logic [1:0]             m_axis_tuser,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int DW = DATA_WIDTH;
    localparam int IW = DW + 8;
    localparam int PW = IW + 2;
    localparam int XW = IW + 3;

    // configuration
    logic        [GAIN_W-1:0] r_prop_gain;
    logic        [GAIN_W-1:0] r_step_igain;
    logic signed [DW-1:0]     r_lim_lo;
    logic signed [DW-1:0]     r_lim_hi;

    // stage 1: input
    logic                 r_s1_valid;
    logic [KIND_W-1:0]    r_s1_kind;
    logic signed [DW-1:0] r_s1_ref;
    logic signed [DW-1:0] r_s1_fb;
    logic signed [DW-1:0] r_s1_want;

    // stage 2: error
    logic                 r_s2_valid;
    logic [KIND_W-1:0]    r_s2_kind;
    logic signed [DW:0]   r_s2_err;
    logic signed [DW-1:0] r_s2_want;

    // stage 3: products
    logic                 r_s3_valid;
    logic [KIND_W-1:0]    r_s3_kind;
    logic signed [PW-1:0] r_s3_prop;
    logic signed [PW-1:0] r_s3_pi;
    logic                 r_s3_err_neg;
    logic                 r_s3_err_pos;
    logic signed [DW-1:0] r_s3_want;

    // stage 4: result and state
    logic                 r_out_valid;
    logic signed [DW-1:0] r_drive;
    logic                 r_clamped;
    logic                 r_accepted;
    logic signed [IW-1:0] r_integ;

    logic out_rdy, s3_free, s2_free, s1_free;
    logic s3_adv;

    logic signed [DW:0]   n_err;
    logic signed [PW-1:0] w_prop;
    logic signed [PW-1:0] w_pi;

    logic signed [XW-1:0] w_lim_lo_x, w_lim_hi_x, w_prop_x;
    logic signed [XW-1:0] w_cand_x, w_sum_x, w_diff_x;
    logic signed [IW-1:0] w_cand;
    logic                 w_lim_ok;

    logic signed [DW-1:0] n_drive;
    logic                 n_clamped;
    logic                 n_accepted;
    logic signed [IW-1:0] n_integ;
    logic signed [DW-1:0] w_preset;
    logic                 w_preset_clamp;

    function automatic logic signed [IW-1:0] sat_integ(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = $signed({{(XW-IW+1){1'b0}}, {(IW-1){1'b1}}});
        lo = ~hi;
        if (v > hi) begin
            return hi[IW-1:0];
        end else if (v < lo) begin
            return lo[IW-1:0];
        end
        return v[IW-1:0];
    endfunction

    // handshake chain: each stage moves on when the next one is free
    assign out_rdy = !r_out_valid || m_axis_tready;
    assign s3_free = !r_s3_valid || out_rdy;
    assign s2_free = !r_s2_valid || s3_free;
    assign s1_free = !r_s1_valid || s2_free;
    assign s3_adv  = r_s3_valid && out_rdy;

    assign s_axis_tready = s1_free;
    assign o_cfg_ready   = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= '0;
            r_step_igain <= '0;
            r_lim_lo     <= DW'(LIMIT_LOW_RESET);
            r_lim_hi     <= DW'(LIMIT_HIGH_RESET);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PROP_GAIN:  r_prop_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_STEP_IGAIN: r_step_igain <= i_cfg_data[GAIN_W-1:0];
                CFG_LIMIT_LOW:  r_lim_lo     <= i_cfg_data[DW-1:0];
                CFG_LIMIT_HIGH: r_lim_hi     <= i_cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && s_axis_tvalid) begin
            r_s1_kind <= s_axis_tuser;
            r_s1_ref  <= s_axis_tdata[DW-1:0];
            r_s1_fb   <= s_axis_tdata[2*DW-1:DW];
            r_s1_want <= s_axis_tdata[3*DW-1:2*DW];
        end
    end

    // stage 2: exact error, one bit wider than the data
    assign n_err = {r_s1_ref[DW-1], r_s1_ref} - {r_s1_fb[DW-1], r_s1_fb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && r_s1_valid) begin
            r_s2_kind <= r_s1_kind;
            r_s2_err  <= n_err;
            r_s2_want <= r_s1_want;
        end
    end

    // stage 3: both gain products
    pic_gain_mul #(
        .DATA_WIDTH     (DATA_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_mul_prop (
        .i_err  (r_s2_err),
        .i_gain (r_prop_gain),
        .o_prod (w_prop)
    );

    pic_gain_mul #(
        .DATA_WIDTH     (DATA_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_mul_integ (
        .i_err  (r_s2_err),
        .i_gain (r_step_igain),
        .o_prod (w_pi)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (s3_free) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_free && r_s2_valid) begin
            r_s3_kind    <= r_s2_kind;
            r_s3_prop    <= w_prop;
            r_s3_pi      <= w_pi;
            r_s3_err_neg <= r_s2_err[DW];
            r_s3_err_pos <= !r_s2_err[DW] && (r_s2_err != '0);
            r_s3_want    <= r_s2_want;
        end
    end

    // stage 4: candidate integral, sum, clamp and integral update
    assign w_lim_ok   = r_lim_lo < r_lim_hi;
    assign w_lim_lo_x = $signed({{(XW-DW){r_lim_lo[DW-1]}}, r_lim_lo});
    assign w_lim_hi_x = $signed({{(XW-DW){r_lim_hi[DW-1]}}, r_lim_hi});
    assign w_prop_x   = $signed({{(XW-PW){r_s3_prop[PW-1]}}, r_s3_prop});
    assign w_cand_x   = $signed({{(XW-IW){r_integ[IW-1]}}, r_integ})
                      + $signed({{(XW-PW){r_s3_pi[PW-1]}}, r_s3_pi});
    assign w_cand     = sat_integ(w_cand_x);
    assign w_sum_x    = w_prop_x + $signed({{(XW-IW){w_cand[IW-1]}}, w_cand});

    always_comb begin
        if (r_s3_want > r_lim_hi) begin
            w_preset       = r_lim_hi;
            w_preset_clamp = 1'b1;
        end else if (r_s3_want < r_lim_lo) begin
            w_preset       = r_lim_lo;
            w_preset_clamp = 1'b1;
        end else begin
            w_preset       = r_s3_want;
            w_preset_clamp = 1'b0;
        end
    end

    assign w_diff_x = $signed({{(XW-DW){w_preset[DW-1]}}, w_preset}) - w_prop_x;

    always_comb begin
        n_drive    = '0;
        n_clamped  = 1'b0;
        n_accepted = 1'b0;
        n_integ    = r_integ;
        unique case (r_s3_kind)
            KIND_CALC: begin
                if (w_lim_ok) begin
                    n_accepted = 1'b1;
                    priority if (w_sum_x > w_lim_hi_x) begin
                        // at the upper limit integrate only downward
                        n_drive   = r_lim_hi;
                        n_clamped = 1'b1;
                        if (r_s3_err_neg) begin
                            n_integ = w_cand;
                        end
                    end else if (w_sum_x < w_lim_lo_x) begin
                        n_drive   = r_lim_lo;
                        n_clamped = 1'b1;
                        if (r_s3_err_pos) begin
                            n_integ = w_cand;
                        end
                    end else begin
                        n_drive = w_sum_x[DW-1:0];
                        n_integ = w_cand;
                    end
                end
            end
            KIND_PRESET: begin
                if (w_lim_ok) begin
                    n_accepted = 1'b1;
                    n_drive    = w_preset;
                    n_clamped  = w_preset_clamp;
                    n_integ    = sat_integ(w_diff_x);
                end
            end
            KIND_CLEAR: begin
                n_accepted = 1'b1;
                n_integ    = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_integ     <= '0;
        end else begin
            if (out_rdy) begin
                r_out_valid <= r_s3_valid;
            end
            if (s3_adv) begin
                r_integ <= n_integ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_adv) begin
            r_drive    <= n_drive;
            r_clamped  <= n_clamped;
            r_accepted <= n_accepted;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'($unsigned(r_drive));
    assign m_axis_tuser  = {r_accepted, r_clamped};

    // a result that was not carried out carries no drive and no clamp flag
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_accepted) |-> (r_drive == '0 && !r_clamped))
        else $error("rejected result carries data");

    // a clear command leaves the integral at zero
    a_clear_integ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s3_adv && r_s3_kind == KIND_CLEAR) |=> (r_integ == '0))
        else $error("integral not cleared");

    // the integral only moves when a command leaves the last stage
    a_integ_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s3_adv |=> $stable(r_integ))
        else $error("integral changed without a command");

    // an in-range compute or preset result leaves no clamp flag with a drive inside the limits
    a_clamp_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s3_adv && r_s3_kind != KIND_CLEAR && n_accepted && !n_clamped) |->
            (n_drive >= r_lim_lo && n_drive <= r_lim_hi))
        else $error("unclamped drive outside limits");

endmodule
